FILE: rtl/bounded_deque_macros.svh
// Assertion macros for the bounded deque top level.
`ifndef BOUNDED_DEQUE_MACROS_SVH
`define BOUNDED_DEQUE_MACROS_SVH
`ifndef SYNTHESIS
`define BDQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bounded_deque: check failed");
`define BDQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bounded_deque: check failed");
`else
`define BDQ_ASSERT(lbl, prop)
`define BDQ_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/bdq_pkg.sv
// Command and status codes for the bounded deque.
`timescale 1ns / 1ps
`default_nettype none
package bdq_pkg;

    typedef logic [2:0] cmd_t;
    typedef logic [1:0] status_t;

    localparam cmd_t CMD_PUSH_FRONT = 3'd0;
    localparam cmd_t CMD_PUSH_BACK  = 3'd1;
    localparam cmd_t CMD_DUMP       = 3'd2;
    localparam cmd_t CMD_POP_FRONT  = 3'd3;
    localparam cmd_t CMD_POP_BACK   = 3'd4;
    localparam cmd_t CMD_CLEAR      = 3'd5;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

endpackage
`default_nettype wire

FILE: rtl/bdq_cmd_if.sv
// Command channel: valid/ready handshake with command and push value.
`timescale 1ns / 1ps
`default_nettype none
interface bdq_cmd_if #(
    parameter int DATA_WIDTH = 32
) ();
    logic                         valid;
    logic                         ready;
    bdq_pkg::cmd_t                cmd;
    logic signed [DATA_WIDTH-1:0] value_in;

    modport source (output valid, output cmd, output value_in, input ready);
    modport sink   (input valid, input cmd, input value_in, output ready);
endinterface
`default_nettype wire

FILE: rtl/bdq_rsp_if.sv
// Response channel: valid/ready handshake with result value and status.
`timescale 1ns / 1ps
`default_nettype none
interface bdq_rsp_if #(
    parameter int DATA_WIDTH = 32
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] value_out;
    bdq_pkg::status_t             status;
    logic                         has_value;
    logic                         last;

    modport source (output valid, output value_out, output status, output has_value,
                    output last, input ready);
    modport sink   (input valid, input value_out, input status, input has_value,
                    input last, output ready);
endinterface
`default_nettype wire

FILE: rtl/bounded_deque.sv
// Bounded double-ended queue over a ring buffer RAM, top level.
// Push, clear, refused push and empty pop/dump: result the cycle after the transaction.
// Pop: result via the RAM read register, then the output register.
// Dump of N entries: via RAM read register, one entry per cycle while output is free.
// One command in flight: taken only in idle with the output register free.
// Reset clears front index, count and output valid; the RAM and output data are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "bounded_deque_macros.svh"
module bounded_deque #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    bdq_cmd_if.sink   cmd_ch,
    bdq_rsp_if.source rsp_ch
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W  = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

    // One-hot sequencer: idle, waiting on pop read data, streaming a dump.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_DUMP = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         front_reg, front_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [AW-1:0]         idx_reg, idx_next;

    // Output register parts the two channels.
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] value_reg, value_next;
    bdq_pkg::status_t      status_reg, status_next;
    logic                  has_value_reg, has_value_next;
    logic                  last_reg, last_next;

    // RAM port signals
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [DATA_WIDTH-1:0] rd_data;

    logic                  cmd_fire;
    logic                  out_free;
    logic                  full;
    logic                  empty;
    logic [CW-1:0]         idx_plus;

    // Ring index add; both operands are below DEPTH, so one subtract wraps it.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_W)
        begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    bdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd_ch.value_in),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register must be empty at the next edge before a command is taken,
    // so a pop's read data always finds room when it lands in S_READ.
    assign out_free      = !out_valid_reg || rsp_ch.ready;
    assign cmd_ch.ready  = (state_reg == S_IDLE) && out_free;
    assign cmd_fire      = cmd_ch.valid && cmd_ch.ready;
    assign full          = (count_reg == DEPTH_C);
    assign empty         = (count_reg == '0);
    assign idx_plus      = CW'(idx_reg) + CW'(1);

    assign rsp_ch.valid     = out_valid_reg;
    assign rsp_ch.value_out = value_reg;
    assign rsp_ch.status    = status_reg;
    assign rsp_ch.has_value = has_value_reg;
    assign rsp_ch.last      = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !rsp_ch.ready;
        value_next     = value_reg;
        status_next    = status_reg;
        has_value_next = has_value_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        wr_addr        = front_reg;
        rd_addr        = ring_add(front_reg, idx_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    // Default single result: no value, last set.
                    value_next     = '0;
                    status_next    = bdq_pkg::ST_OK;
                    has_value_next = 1'b0;
                    last_next      = 1'b1;
                    case (cmd_ch.cmd)
                        bdq_pkg::CMD_PUSH_FRONT:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                            begin
                                status_next = bdq_pkg::ST_FULL;
                            end
                            else
                            begin
                                front_next = (front_reg == '0) ? LAST_IDX
                                                               : front_reg - AW'(1);
                                wr_en      = 1'b1;
                                wr_addr    = front_next;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        bdq_pkg::CMD_PUSH_BACK:
                        begin
                            out_valid_next = 1'b1;
                            if (full)
                            begin
                                status_next = bdq_pkg::ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = ring_add(front_reg, count_reg[AW-1:0]);
                                count_next = count_reg + CW'(1);
                            end
                        end
                        bdq_pkg::CMD_DUMP:
                        begin
                            if (empty)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = bdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                idx_next   = '0;
                                rd_addr    = front_reg;
                                state_next = S_DUMP;
                            end
                        end
                        bdq_pkg::CMD_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = bdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                rd_addr    = front_reg;
                                front_next = ring_add(front_reg, AW'(1));
                                count_next = count_reg - CW'(1);
                                state_next = S_READ;
                            end
                        end
                        bdq_pkg::CMD_POP_BACK:
                        begin
                            if (empty)
                            begin
                                out_valid_next = 1'b1;
                                status_next    = bdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                rd_addr    = ring_add(front_reg, count_next[AW-1:0]);
                                state_next = S_READ;
                            end
                        end
                        bdq_pkg::CMD_CLEAR:
                        begin
                            out_valid_next = 1'b1;
                            front_next     = '0;
                            count_next     = '0;
                        end
                        default:
                        begin
                            // unused codes: no result, no state change
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // Pop data lands; output register is known empty here.
                out_valid_next = 1'b1;
                value_next     = rd_data;
                status_next    = bdq_pkg::ST_OK;
                has_value_next = 1'b1;
                last_next      = 1'b1;
                state_next     = S_IDLE;
            end
            S_DUMP:
            begin
                // rd_data always holds the entry at idx_reg: the read address
                // tracks idx_next every cycle and nothing writes during a dump.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    value_next     = rd_data;
                    status_next    = bdq_pkg::ST_OK;
                    has_value_next = 1'b1;
                    last_next      = (idx_plus == count_reg);
                    if (idx_plus == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                        rd_addr  = ring_add(front_reg, idx_next);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        status_reg    <= status_next;
        has_value_reg <= has_value_next;
        last_reg      <= last_next;
    end

    // Checks
    `BDQ_ASSERT(a_count_bound, count_reg <= DEPTH_C)
    `BDQ_ASSERT(a_read_room, (state_reg == S_READ) |-> !out_valid_reg)
    `BDQ_ASSERT(a_dump_index, (state_reg == S_DUMP) |-> (CW'(idx_reg) < count_reg))
    `BDQ_ASSERT_NEXT(a_count_hold, !cmd_fire, $stable(count_reg) && $stable(front_reg))

endmodule
`default_nettype wire

FILE: rtl/bdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

FILE: tb/sv/tb_bounded_deque.sv
// Self-checking testbench for the bounded deque: random bursts of commands against a predictor.
`timescale 1ns / 1ps
module tb_bounded_deque;

    localparam int DEPTH        = 16;
    localparam int DATA_WIDTH   = 32;
    localparam int IDX_W        = $clog2(DEPTH);
    localparam int RANDOM_ITEMS = 320;
    // Worst case is every command dumping a full queue with each result stalled
    // by the receiver; this is several times that.
    localparam int CYCLE_LIMIT  = 400000;
    // Pop and dump answer through the RAM read register and the output register; leave some slack.
    localparam int DRAIN_CYCLES = 16;

    // Codes the block must ignore (no results, no state change).
    localparam bdq_pkg::cmd_t CMD_RSVD_LO = 3'd6;
    localparam bdq_pkg::cmd_t CMD_RSVD_HI = 3'd7;

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    typedef struct packed {
        bdq_pkg::cmd_t op;
        data_t         data;
    } deque_cmd_t;

    typedef struct packed {
        data_t            data;
        bdq_pkg::status_t status;
        logic             has_value;
        logic             last;
    } deque_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    bdq_cmd_if #(.DATA_WIDTH(DATA_WIDTH)) cmd_ch ();
    bdq_rsp_if #(.DATA_WIDTH(DATA_WIDTH)) rsp_ch ();

    bounded_deque #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_ch),
        .rsp_ch (rsp_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Commands waiting to be driven, and results the predictor says are owed.
    deque_cmd_t pending_cmds[$];
    deque_rsp_t owed_results[$];
    int         error_count = 0;

    // Predictor's own copy of the deque: ring store, front index, entry count.
    data_t            dq_store [DEPTH];
    logic [IDX_W-1:0] dq_front = '0;
    logic [IDX_W:0]   dq_count = '0;

    // Corner values for pushes: both extremes, zero, all ones.
    data_t corner_vals [4] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sd1};

    task automatic owe_result(input data_t data, input bdq_pkg::status_t status,
                              input logic has_value, input logic last);
        deque_rsp_t r;
        r.data      = data;
        r.status    = status;
        r.has_value = has_value;
        r.last      = last;
        owed_results.push_back(r);
    endtask

    // Update the predicted deque for one accepted transaction and queue its results.
    task automatic run_deque_cmd(input bdq_pkg::cmd_t op, input data_t data);
        logic [IDX_W-1:0] slot;
        int               i;
        case (op)
            bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK:
            begin
                if (dq_count == DEPTH)
                    owe_result('0, bdq_pkg::ST_FULL, 1'b0, 1'b1);   // full: value dropped
                else
                begin
                    if (op == bdq_pkg::CMD_PUSH_FRONT)
                    begin
                        dq_front           = dq_front - 1'b1;
                        dq_store[dq_front] = data;
                    end
                    else
                    begin
                        slot           = dq_front + dq_count[IDX_W-1:0];
                        dq_store[slot] = data;
                    end
                    dq_count = dq_count + 1'b1;
                    owe_result('0, bdq_pkg::ST_OK, 1'b0, 1'b1);
                end
            end
            bdq_pkg::CMD_DUMP:
            begin
                if (dq_count == 0)
                    owe_result('0, bdq_pkg::ST_EMPTY, 1'b0, 1'b1);
                else
                    for (i = 0; i < dq_count; i++)
                    begin
                        slot = dq_front + IDX_W'(i);
                        owe_result(dq_store[slot], bdq_pkg::ST_OK, 1'b1, (i == dq_count - 1));
                    end
            end
            bdq_pkg::CMD_POP_FRONT:
            begin
                if (dq_count == 0)
                    owe_result('0, bdq_pkg::ST_EMPTY, 1'b0, 1'b1);
                else
                begin
                    owe_result(dq_store[dq_front], bdq_pkg::ST_OK, 1'b1, 1'b1);
                    dq_front = dq_front + 1'b1;
                    dq_count = dq_count - 1'b1;
                end
            end
            bdq_pkg::CMD_POP_BACK:
            begin
                if (dq_count == 0)
                    owe_result('0, bdq_pkg::ST_EMPTY, 1'b0, 1'b1);
                else
                begin
                    dq_count = dq_count - 1'b1;
                    slot     = dq_front + dq_count[IDX_W-1:0];
                    owe_result(dq_store[slot], bdq_pkg::ST_OK, 1'b1, 1'b1);
                end
            end
            bdq_pkg::CMD_CLEAR:
            begin
                dq_front = '0;
                dq_count = '0;
                owe_result('0, bdq_pkg::ST_OK, 1'b0, 1'b1);
            end
            default:
            begin
                // reserved codes: ignored by the block
            end
        endcase
    endtask

    task automatic queue_cmd(input bdq_pkg::cmd_t op, input data_t data);
        deque_cmd_t c;
        c.op   = op;
        c.data = data;
        pending_cmds.push_back(c);
    endtask

    function automatic data_t pick_data();
        if ($urandom_range(0, 7) == 0)
            return corner_vals[$urandom_range(0, 3)];
        return data_t'($urandom);
    endfunction

    // Stimulus: a directed opening, then random phases that lean toward
    // filling or draining so the queue regularly hits both full and empty.
    initial
    begin : stim_fill
        int            i;
        int            counted;
        int            phase_len;
        int            push_pct;
        int            roll;
        bdq_pkg::cmd_t op;

        // empty pop at both ends, empty dump, reserved codes
        queue_cmd(bdq_pkg::CMD_POP_FRONT, pick_data());
        queue_cmd(bdq_pkg::CMD_POP_BACK, pick_data());
        queue_cmd(bdq_pkg::CMD_DUMP, pick_data());
        queue_cmd(CMD_RSVD_LO, pick_data());
        queue_cmd(CMD_RSVD_HI, pick_data());
        // fill to capacity from both ends, corner values first
        for (i = 0; i < DEPTH; i++)
            queue_cmd((i % 2) ? bdq_pkg::CMD_PUSH_BACK : bdq_pkg::CMD_PUSH_FRONT,
                      (i < 4) ? corner_vals[i] : data_t'($urandom));
        // push on a full queue at both ends, then dump the full ring
        queue_cmd(bdq_pkg::CMD_PUSH_FRONT, corner_vals[0]);
        queue_cmd(bdq_pkg::CMD_PUSH_BACK, corner_vals[1]);
        queue_cmd(bdq_pkg::CMD_DUMP, '0);
        queue_cmd(bdq_pkg::CMD_POP_FRONT, '0);
        queue_cmd(bdq_pkg::CMD_POP_BACK, '0);
        queue_cmd(bdq_pkg::CMD_CLEAR, '0);
        queue_cmd(bdq_pkg::CMD_POP_BACK, '0);

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            phase_len = $urandom_range(10, 40);
            case ($urandom_range(0, 2))
                0:       push_pct = 75;
                1:       push_pct = 45;
                default: push_pct = 20;
            endcase
            for (i = 0; i < phase_len; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 2)
                    op = $urandom_range(0, 1) ? CMD_RSVD_HI : CMD_RSVD_LO;
                else if (roll < 4)
                    op = bdq_pkg::CMD_CLEAR;
                else if (roll < 14)
                    op = bdq_pkg::CMD_DUMP;
                else if (roll < 14 + push_pct)
                    op = $urandom_range(0, 1) ? bdq_pkg::CMD_PUSH_BACK
                                              : bdq_pkg::CMD_PUSH_FRONT;
                else
                    op = $urandom_range(0, 1) ? bdq_pkg::CMD_POP_BACK
                                              : bdq_pkg::CMD_POP_FRONT;
                queue_cmd(op, pick_data());
                if (op != CMD_RSVD_LO && op != CMD_RSVD_HI)
                    counted++;
            end
        end
    end

    // Command driver: bursts of random length separated by random gaps.
    // valid stays up until the transaction completes.
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        if (!rst_n)
        begin
            cmd_ch.valid    <= 1'b0;
            cmd_ch.cmd      <= bdq_pkg::CMD_CLEAR;
            cmd_ch.value_in <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                run_deque_cmd(pending_cmds[0].op, pending_cmds[0].data);
                void'(pending_cmds.pop_front());
                if (burst_left > 0)
                    burst_left--;
            end
            else if (!cmd_ch.valid && gap_left > 0)
                gap_left--;

            // burst done: pick the next one; a zero gap gives back-to-back runs
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
            end

            if (gap_left == 0 && pending_cmds.size() > 0)
            begin
                cmd_ch.valid    <= 1'b1;
                cmd_ch.cmd      <= pending_cmds[0].op;
                cmd_ch.value_in <= pending_cmds[0].data;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // Response ready follows a 16-bit stall pattern that is redrawn whenever its
    // age counter runs out; about a third of the time it is all ones (no stalls).
    logic [15:0] stall_pattern;
    int          pattern_pos;
    int          pattern_age;

    always @(posedge clk or negedge rst_n)
    begin : rsp_stall
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_pattern = '1;
            pattern_pos   = 0;
            pattern_age   = 0;
        end
        else
        begin
            if (pattern_age == 0)
            begin
                pattern_age = 64;
                if ($urandom_range(0, 2) == 0)
                    stall_pattern = '1;
                else
                    stall_pattern = 16'($urandom) | 16'h0001;   // never stall forever
            end
            pattern_age--;
            rsp_ch.ready <= stall_pattern[pattern_pos];
            pattern_pos = (pattern_pos + 1) % 16;
        end
    end

    // Response monitor: each completed transaction against the oldest owed result.
    always @(posedge clk)
    begin : rsp_monitor
        deque_rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (owed_results.size() == 0)
            begin
                $error("unexpected transaction: value_out %0d status %0d",
                       rsp_ch.value_out, rsp_ch.status);
                error_count++;
            end
            else
            begin
                want = owed_results.pop_front();
                if (rsp_ch.value_out !== want.data)
                begin
                    $error("value_out: expected %0d, got %0d", want.data, rsp_ch.value_out);
                    error_count++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    error_count++;
                end
                if (rsp_ch.has_value !== want.has_value)
                begin
                    $error("has_value: expected %0b, got %0b", want.has_value,
                           rsp_ch.has_value);
                    error_count++;
                end
                if (rsp_ch.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, rsp_ch.last);
                    error_count++;
                end
            end
        end
    end

    // Watchdog.
    int cycle_count = 0;

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, owed_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin : run_ctrl
        // every input known from time zero
        rst_n           = 1'b0;
        cmd_ch.valid    = 1'b0;
        cmd_ch.cmd      = bdq_pkg::CMD_CLEAR;
        cmd_ch.value_in = '0;
        rsp_ch.ready    = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() > 0)
            @(posedge clk);
        while (owed_results.size() > 0)
            @(posedge clk);
        // catch any stray trailing transaction
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
